### hw/rtl/smt_pkg.sv
// sorted mac table package: table depth, widths, command and status codes,
// entry and result records, channel clamp and blank result functions; no dependencies
`default_nettype none
package smt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_CHANNEL = 14;
    localparam int IN_W        = 120;
    localparam int OUT_W       = 128;

    typedef enum logic [3:0] {
        FN_LOOKUP   = 4'd0,
        FN_INSERT   = 4'd1,
        FN_REMOVE   = 4'd2,
        FN_SELECT   = 4'd3,
        FN_DESELECT = 4'd4,
        FN_SETCH    = 4'd5,
        FN_READ     = 4'd6,
        FN_CLEAR    = 4'd7,
        FN_SELALL   = 4'd8,
        FN_DESELALL = 4'd9
    } func_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [47:0] mac;
        logic [47:0] bssid;
        logic        has_bssid;
        logic [3:0]  channel;
        logic        selected;
    } entry_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        entry_t           ent;
    } res_t;

    // channel outside 1..14 becomes 1
    function automatic logic [3:0] clamp_channel(input logic [7:0] raw);
        logic [3:0] c;
        c = 4'd1;
        if (raw >= 8'd1 && raw <= 8'(MAX_CHANNEL))
        begin
            c = raw[3:0];
        end
        return c;
    endfunction

    // result that describes no entry
    function automatic res_t blank_res(input logic [1:0] st);
        res_t r;
        r = '0;
        r.status = st;
        r.ent.channel = 4'd1;
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/sorted_mac_table_unit.sv
// sorted mac table: 32 entries in mac order, binary search, shifting insert
// and remove under one sequencer; depends on smt_pkg
// one entry moves or one key compare is made per cycle through one port
// throughput: one command at a time, not ready until the command ends
// reset: rst_n asynchronous active low clears count, sequencer and output
//   valid; entry contents are not cleared
`default_nettype none
module sorted_mac_table_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // func, mac_addr, bssid_addr, has_bssid, channel, select_flag,
    // force_evict, entry_index, zero fill
    input  wire logic [smt_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // status, result_index, entry_mac, entry_bssid, entry_has_bssid,
    // entry_channel, entry_selected, entry_count, selected_count, zero fill
    output logic [smt_pkg::OUT_W-1:0]      m_axis_tdata
);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_DROP, S_INS, S_RESP} state_t;

    localparam int IW = smt_pkg::IDX_W;
    localparam int CW = smt_pkg::CNT_W;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            total_reg, total_next;
    logic [CW-1:0]            selcnt_reg, selcnt_next;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic                     reins_reg, reins_next;
    smt_pkg::entry_t          hold_reg, hold_next;
    smt_pkg::res_t            res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic [smt_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    smt_pkg::entry_t          ent_reg [smt_pkg::TABLE_DEPTH];

    // entry write port controls
    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    smt_pkg::entry_t          wr_data;
    logic                     selall_en;
    logic                     selall_val;

    // input fields
    smt_pkg::func_t           in_func;
    logic [47:0]              in_mac;
    logic [47:0]              in_bssid;
    logic                     in_hasb;
    logic [7:0]               in_ch;
    logic                     in_sel;
    logic                     in_force;
    logic [4:0]               in_idx;

    logic                     accept;
    logic                     idx_ok;
    logic [IW-1:0]            idx_a;
    smt_pkg::entry_t          ent_idx;
    logic [CW:0]              mid_sum;
    logic [CW-1:0]            mid;
    smt_pkg::entry_t          ent_mid;
    logic [CW-1:0]            ptr_inc;
    logic [CW-1:0]            ptr_dec;
    smt_pkg::entry_t          ent_tmp;

    assign in_func  = smt_pkg::func_t'(s_axis_tdata[3:0]);
    assign in_mac   = s_axis_tdata[51:4];
    assign in_bssid = s_axis_tdata[99:52];
    assign in_hasb  = s_axis_tdata[100];
    assign in_ch    = s_axis_tdata[108:101];
    assign in_sel   = s_axis_tdata[109];
    assign in_force = s_axis_tdata[110];
    assign in_idx   = s_axis_tdata[115:111];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign idx_ok  = {{(CW > 5 ? CW - 5 : 0){1'b0}}, in_idx} < total_reg;
    assign idx_a   = IW'(in_idx);
    assign ent_idx = ent_reg[idx_a];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);
    assign mid     = mid_sum[CW:1];
    assign ent_mid = ent_reg[mid[IW-1:0]];
    assign ptr_inc = ptr_reg + CW'(1);
    assign ptr_dec = ptr_reg - CW'(1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        selcnt_next    = selcnt_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        reins_next     = reins_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = hold_reg;
        selall_en      = 1'b0;
        selall_val     = 1'b0;
        ent_tmp        = ent_idx;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    res_next   = smt_pkg::blank_res(smt_pkg::ST_OK);
                    case (in_func) inside
                        smt_pkg::FN_LOOKUP:
                        begin
                            lo_next       = '0;
                            hi_next       = total_reg;
                            hold_next.mac = in_mac;
                            state_next    = S_SEARCH;
                        end
                        smt_pkg::FN_INSERT:
                        begin
                            hold_next.mac       = in_mac;
                            hold_next.bssid     = in_hasb ? in_bssid : 48'd0;
                            hold_next.has_bssid = in_hasb;
                            hold_next.channel   = smt_pkg::clamp_channel(in_ch);
                            hold_next.selected  = in_sel;
                            if (total_reg == CW'(smt_pkg::TABLE_DEPTH))
                            begin
                                if (!in_force)
                                begin
                                    res_next = smt_pkg::blank_res(smt_pkg::ST_FULL);
                                end
                                else
                                begin
                                    // evict the smallest mac first
                                    selcnt_next = selcnt_reg - CW'(ent_reg[0].selected);
                                    ptr_next    = '0;
                                    reins_next  = 1'b1;
                                    state_next  = S_DROP;
                                end
                            end
                            else
                            begin
                                ptr_next   = total_reg;
                                state_next = S_INS;
                            end
                        end
                        smt_pkg::FN_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                res_next = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                            end
                            else
                            begin
                                res_next.index = idx_a;
                                res_next.ent   = ent_idx;
                                selcnt_next    = selcnt_reg - CW'(ent_idx.selected);
                                ptr_next       = CW'(in_idx);
                                reins_next     = 1'b0;
                                state_next     = S_DROP;
                            end
                        end
                        smt_pkg::FN_SELECT, smt_pkg::FN_DESELECT:
                        begin
                            if (!idx_ok)
                            begin
                                res_next = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                            end
                            else
                            begin
                                ent_tmp.selected = (in_func == smt_pkg::FN_SELECT);
                                wr_en            = 1'b1;
                                wr_addr          = idx_a;
                                wr_data          = ent_tmp;
                                res_next.index   = idx_a;
                                res_next.ent     = ent_tmp;
                                selcnt_next      = selcnt_reg + CW'(ent_tmp.selected)
                                                   - CW'(ent_idx.selected);
                            end
                        end
                        smt_pkg::FN_SETCH:
                        begin
                            if (!idx_ok)
                            begin
                                res_next = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                            end
                            else
                            begin
                                ent_tmp.channel = smt_pkg::clamp_channel(in_ch);
                                hold_next       = ent_tmp;
                                selcnt_next     = selcnt_reg - CW'(ent_idx.selected);
                                ptr_next        = CW'(in_idx);
                                reins_next      = 1'b1;
                                state_next      = S_DROP;
                            end
                        end
                        smt_pkg::FN_READ:
                        begin
                            if (!idx_ok)
                            begin
                                res_next = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                            end
                            else
                            begin
                                res_next.index = idx_a;
                                res_next.ent   = ent_idx;
                            end
                        end
                        smt_pkg::FN_CLEAR:
                        begin
                            total_next  = '0;
                            selcnt_next = '0;
                        end
                        smt_pkg::FN_SELALL, smt_pkg::FN_DESELALL:
                        begin
                            selall_en   = 1'b1;
                            selall_val  = (in_func == smt_pkg::FN_SELALL);
                            selcnt_next = selall_val ? total_reg : '0;
                        end
                        default:
                        begin
                            res_next = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                        end
                    endcase
                end
            end
            // one midpoint probe per cycle over [lo, hi)
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    if (ent_mid.mac == hold_reg.mac)
                    begin
                        res_next.index = mid[IW-1:0];
                        res_next.ent   = ent_mid;
                        state_next     = S_RESP;
                    end
                    else if (hold_reg.mac < ent_mid.mac)
                    begin
                        hi_next = mid;
                    end
                    else
                    begin
                        lo_next = mid + CW'(1);
                    end
                end
                else
                begin
                    res_next   = smt_pkg::blank_res(smt_pkg::ST_NOTFOUND);
                    state_next = S_RESP;
                end
            end
            // close the gap, one entry per cycle
            S_DROP:
            begin
                if (ptr_inc < total_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[IW-1:0];
                    wr_data  = ent_reg[ptr_inc[IW-1:0]];
                    ptr_next = ptr_inc;
                end
                else
                begin
                    total_next = total_reg - CW'(1);
                    ptr_next   = total_reg - CW'(1);
                    state_next = reins_reg ? S_INS : S_RESP;
                end
            end
            // open a slot from the top, one entry per cycle
            S_INS:
            begin
                if (ptr_reg != '0 && ent_reg[ptr_dec[IW-1:0]].mac > hold_reg.mac)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_reg[IW-1:0];
                    wr_data  = ent_reg[ptr_dec[IW-1:0]];
                    ptr_next = ptr_dec;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_addr        = ptr_reg[IW-1:0];
                    wr_data        = hold_reg;
                    total_next     = total_reg + CW'(1);
                    selcnt_next    = selcnt_reg + CW'(hold_reg.selected);
                    res_next       = smt_pkg::blank_res(smt_pkg::ST_OK);
                    res_next.index = ptr_reg[IW-1:0];
                    res_next.ent   = hold_reg;
                    state_next     = S_RESP;
                end
            end
            // hand the beat to the output register
            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'd0, 6'(selcnt_reg), 6'(total_reg),
                                      res_reg.ent.selected, res_reg.ent.channel,
                                      res_reg.ent.has_bssid, res_reg.ent.bssid,
                                      res_reg.ent.mac, 5'(res_reg.index),
                                      res_reg.status};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            selcnt_reg    <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            ptr_reg       <= '0;
            reins_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            selcnt_reg    <= selcnt_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            ptr_reg       <= ptr_next;
            reins_reg     <= reins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wr_addr] <= wr_data;
        end
        if (selall_en)
        begin
            for (int i = 0; i < smt_pkg::TABLE_DEPTH; i++)
            begin
                if (CW'(i) < total_reg)
                begin
                    ent_reg[i].selected <= selall_val;
                end
            end
        end
    end

    // checks
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(smt_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    a_sel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (selcnt_reg <= total_reg))
        else $error("selected count above entry count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("ready right after a command was taken");

    a_resp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || m_axis_tready)) |=> out_valid_reg)
        else $error("result not presented");

endmodule
`default_nettype wire
